// ----- rtl/isk_pkg.sv -----
// Shared types and constants for the info string key lookup block.
// Used by every module of the block; depends on nothing else.

package isk_pkg;

    localparam int KEY_MAX = 64;
    localparam int KEY_AW  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int KEY_CW  = $clog2(KEY_MAX + 1);

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    localparam int RESQ_DEPTH = 2;
    localparam int RESQ_AW    = $clog2(RESQ_DEPTH);
    localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

    localparam logic [7:0] SEP_CHAR  = 8'h5C;
    localparam logic [7:0] END_CHAR  = 8'h00;
    localparam logic [7:0] UPPER_LO  = 8'h41;
    localparam logic [7:0] UPPER_HI  = 8'h5A;
    localparam logic [7:0] CASE_STEP = 8'h20;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_STRING = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       byte_valid;
        logic       found;
        logic       last;
    } t_out;

    typedef enum logic [1:0] {
        K_CLEAR,
        K_APPEND,
        K_STRING
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] raw_byte;
        logic [7:0] low_byte;
        logic       is_end;
        logic       is_sep;
    } t_cmd;

    typedef enum logic [2:0] {
        PH_START,
        PH_KEY,
        PH_VAL_OUT,
        PH_VAL_SKIP,
        PH_DRAIN
    } t_phase;

endpackage

// ----- rtl/info_string_key_lookup.sv -----
// Top level of the info string key lookup block.
// Depends on isk_pkg, isk_front, isk_back and isk_res_queue.
//
//   Channel   Handshake          Payload
//   input     push / full        i_item   (operation, data_byte)
//   result    empty / pop        o_result (value_byte, byte_valid, found, last)
//
// One item is taken per cycle while full is low; a result passes through the
// command queue and the result queue before it reaches the result ports.
// The back end reads the key memory one entry ahead, so it can take the next
// string byte without waiting on the read. Reset is synchronous and clears
// the queues and scan state; the key memory is not cleared. A stalled result
// side fills the result queue and then the command queue before full rises.

module info_string_key_lookup import isk_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    output logic empty,
    input  logic pop,
    output t_out o_result
);

    logic w_cmd_pop;
    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_res_ready;
    logic w_res_push;
    t_out w_res;

    isk_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd)
    );

    isk_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_ready (w_res_ready),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    isk_res_queue u_res_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_push  (w_res_push),
        .i_res       (w_res),
        .o_res_ready (w_res_ready),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule

// ----- rtl/isk_front.sv -----
// Front end: decodes and classifies incoming items into commands and
// buffers them in a short queue; items with an unknown operation are dropped. Depends on isk_pkg.

module isk_front import isk_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    input  logic i_cmd_pop,
    output logic o_cmd_valid,
    output t_cmd o_cmd
);

    t_cmd                r_slot [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [CMDQ_AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CMDQ_CW-1:0]  r_count, n_count;
    t_cmd                w_cmd;
    logic                w_keep;
    logic                w_wr;
    logic                w_rd;

    always_comb begin
        w_cmd.raw_byte = i_item.data_byte;
        if (i_item.data_byte inside {[UPPER_LO:UPPER_HI]}) begin
            w_cmd.low_byte = i_item.data_byte + CASE_STEP;
        end else begin
            w_cmd.low_byte = i_item.data_byte;
        end
        w_cmd.is_end = (i_item.data_byte == END_CHAR);
        w_cmd.is_sep = (i_item.data_byte == SEP_CHAR);
        w_keep = 1'b1;
        case (i_item.operation)
            OP_CLEAR:  w_cmd.kind = K_CLEAR;
            OP_APPEND: w_cmd.kind = K_APPEND;
            OP_STRING: w_cmd.kind = K_STRING;
            default: begin
                w_cmd.kind = K_CLEAR;
                w_keep = 1'b0;
            end
        endcase
    end

    assign full        = (r_count == CMDQ_CW'(CMDQ_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign w_wr        = push && !full && w_keep;
    assign w_rd        = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (!w_wr && w_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

// ----- rtl/isk_back.sv -----
// Back end: holds the query key memory and runs the string scan state
// machine, one command per cycle while the result queue has room. Depends on isk_pkg.

module isk_back import isk_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    input  logic i_res_ready,
    output logic o_res_push,
    output t_out o_res
);

    logic [7:0]        r_mem [KEY_MAX];
    logic [7:0]        r_rd;
    t_phase            r_phase, n_phase;
    logic [KEY_CW-1:0] r_len, n_len;
    logic [KEY_CW-1:0] r_pos, n_pos;
    logic              r_ovf, n_ovf;
    logic              r_mm, n_mm;
    logic              w_step;
    logic              w_we;
    logic              w_key_byte;
    logic              w_mm_base;

    assign w_step    = i_cmd_valid && i_res_ready;
    assign o_cmd_pop = w_step;

    always_comb begin
        n_phase    = r_phase;
        n_len      = r_len;
        n_pos      = r_pos;
        n_ovf      = r_ovf;
        n_mm       = r_mm;
        w_we       = 1'b0;
        w_key_byte = 1'b0;
        w_mm_base  = r_mm;
        o_res_push = 1'b0;
        o_res      = '0;
        if (w_step) begin
            case (i_cmd.kind)
                K_CLEAR: begin
                    n_len   = '0;
                    n_ovf   = 1'b0;
                    n_phase = PH_START;
                    n_pos   = '0;
                end
                K_APPEND: begin
                    if (r_len < KEY_CW'(KEY_MAX)) begin
                        w_we  = 1'b1;
                        n_len = r_len + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_phase = PH_START;
                    n_pos   = '0;
                end
                K_STRING: begin
                    case (r_phase)
                        PH_START: begin
                            n_phase   = PH_KEY;
                            n_pos     = '0;
                            n_mm      = 1'b0;
                            w_mm_base = 1'b0;
                            w_key_byte = !i_cmd.is_sep;
                        end
                        PH_KEY: begin
                            w_key_byte = 1'b1;
                        end
                        PH_VAL_OUT: begin
                            o_res_push = 1'b1;
                            o_res.found = 1'b1;
                            if (i_cmd.is_end) begin
                                n_phase    = PH_START;
                                n_pos      = '0;
                                o_res.last = 1'b1;
                            end else if (i_cmd.is_sep) begin
                                n_phase    = PH_DRAIN;
                                o_res.last = 1'b1;
                            end else begin
                                o_res.value_byte = i_cmd.raw_byte;
                                o_res.byte_valid = 1'b1;
                            end
                        end
                        PH_VAL_SKIP: begin
                            if (i_cmd.is_end) begin
                                n_phase    = PH_START;
                                n_pos      = '0;
                                o_res_push = 1'b1;
                                o_res.last = 1'b1;
                            end else if (i_cmd.is_sep) begin
                                n_phase = PH_KEY;
                                n_pos   = '0;
                                n_mm    = 1'b0;
                            end
                        end
                        PH_DRAIN: begin
                            if (i_cmd.is_end) begin
                                n_phase = PH_START;
                                n_pos   = '0;
                            end
                        end
                        default: begin
                            n_phase = PH_START;
                            n_pos   = '0;
                        end
                    endcase
                    if (w_key_byte) begin
                        if (i_cmd.is_end) begin
                            n_phase    = PH_START;
                            n_pos      = '0;
                            o_res_push = 1'b1;
                            o_res.last = 1'b1;
                        end else if (i_cmd.is_sep) begin
                            if (!w_mm_base && !r_ovf && r_pos == r_len) begin
                                n_phase = PH_VAL_OUT;
                            end else begin
                                n_phase = PH_VAL_SKIP;
                            end
                        end else begin
                            if (r_pos < r_len) begin
                                n_mm = w_mm_base || (r_rd != i_cmd.low_byte);
                            end else begin
                                n_mm = 1'b1;
                            end
                            if (r_pos < KEY_CW'(KEY_MAX)) begin
                                n_pos = r_pos + 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_START;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_len   <= '0;
            r_pos   <= '0;
            r_ovf   <= 1'b0;
            r_mm    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_ovf   <= n_ovf;
            r_mm    <= n_mm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_len[KEY_AW-1:0]] <= i_cmd.low_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we && r_len[KEY_AW-1:0] == n_pos[KEY_AW-1:0]) begin
            r_rd <= i_cmd.low_byte;
        end else begin
            r_rd <= r_mem[n_pos[KEY_AW-1:0]];
        end
    end

endmodule

// ----- rtl/isk_res_queue.sv -----
// Result queue between the back end and the output channel.
// Depends on isk_pkg.

module isk_res_queue import isk_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_res_push,
    input  t_out i_res,
    output logic o_res_ready,
    output logic empty,
    input  logic pop,
    output t_out o_result
);

    t_out                r_slot [RESQ_DEPTH];
    logic [RESQ_AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [RESQ_AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [RESQ_CW-1:0]  r_count, n_count;
    logic                w_wr;
    logic                w_rd;

    assign o_res_ready = (r_count != RESQ_CW'(RESQ_DEPTH));
    assign empty       = (r_count == '0);
    assign o_result    = r_slot[r_rd_ptr];
    assign w_wr        = i_res_push && o_res_ready;
    assign w_rd        = pop && !empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (!w_wr && w_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wr_ptr] <= i_res;
        end
    end

endmodule

// ----- bench/isk_lookup_checker.sv -----
`timescale 1ns / 100ps
// Checker for the info string key lookup block: predicts every result from the
// accepted input items and compares them with the results taken from the block.
// Depends on isk_pkg for the item types, operation codes and character constants.

module isk_lookup_checker import isk_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  logic i_full,
    input  t_in  i_item,
    input  logic i_empty,
    input  logic i_pop,
    input  t_out i_result,
    output int   o_errors,
    output int   o_pending,
    output int   o_hits,
    output int   o_misses
);

    t_out       lookup_answers[$];
    logic [7:0] key_mem [KEY_MAX];
    int         key_len;
    logic       key_ovf;
    t_phase     phase;
    int         pair_pos;
    logic       pair_miss;
    int         errors = 0;
    int         hits = 0;
    int         misses = 0;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c inside {[UPPER_LO:UPPER_HI]}) ? c + CASE_STEP : c;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 100) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    task automatic add_answer(input logic [7:0] v, input logic bv, input logic f,
                              input logic l);
        t_out r;
        r.value_byte = v;
        r.byte_valid = bv;
        r.found      = f;
        r.last       = l;
        lookup_answers.push_back(r);
    endtask

    task automatic open_pair();
        phase     = PH_KEY;
        pair_pos  = 0;
        pair_miss = 1'b0;
    endtask

    task automatic pair_key_char(input logic [7:0] c);
        if (c == END_CHAR) begin
            phase = PH_START;
            add_answer(8'h00, 1'b0, 1'b0, 1'b1);
        end else if (c == SEP_CHAR) begin
            if (!pair_miss && !key_ovf && pair_pos == key_len) begin
                phase = PH_VAL_OUT;
            end else begin
                phase = PH_VAL_SKIP;
            end
        end else begin
            if (pair_pos < key_len && pair_pos < KEY_MAX) begin
                if (key_mem[pair_pos] != fold_case(c)) begin
                    pair_miss = 1'b1;
                end
            end else begin
                pair_miss = 1'b1;
            end
            if (pair_pos < KEY_MAX) begin
                pair_pos++;
            end
        end
    endtask

    task automatic scan_char(input logic [7:0] c);
        case (phase)
            PH_START: begin
                open_pair();
                if (c != SEP_CHAR) begin
                    pair_key_char(c);
                end
            end
            PH_KEY: begin
                pair_key_char(c);
            end
            PH_VAL_OUT: begin
                if (c == END_CHAR) begin
                    phase = PH_START;
                    add_answer(8'h00, 1'b0, 1'b1, 1'b1);
                end else if (c == SEP_CHAR) begin
                    phase = PH_DRAIN;
                    add_answer(8'h00, 1'b0, 1'b1, 1'b1);
                end else begin
                    add_answer(c, 1'b1, 1'b1, 1'b0);
                end
            end
            PH_VAL_SKIP: begin
                if (c == END_CHAR) begin
                    phase = PH_START;
                    add_answer(8'h00, 1'b0, 1'b0, 1'b1);
                end else if (c == SEP_CHAR) begin
                    open_pair();
                end
            end
            default: begin
                if (c == END_CHAR) begin
                    phase = PH_START;
                end
            end
        endcase
    endtask

    task automatic step_lookup(input t_in it);
        case (it.operation)
            OP_CLEAR: begin
                key_len = 0;
                key_ovf = 1'b0;
                phase   = PH_START;
            end
            OP_APPEND: begin
                if (key_len < KEY_MAX) begin
                    key_mem[key_len] = fold_case(it.data_byte);
                    key_len++;
                end else begin
                    key_ovf = 1'b1;
                end
                phase = PH_START;
            end
            OP_STRING: begin
                scan_char(it.data_byte);
            end
            default: ;
        endcase
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (lookup_answers.size() == 0) begin
            report_mismatch($sformatf("result %h arrived with none expected", got));
        end else begin
            want = lookup_answers.pop_front();
            if (got.value_byte !== want.value_byte) begin
                report_mismatch($sformatf("value_byte %h, expected %h",
                                          got.value_byte, want.value_byte));
            end
            if (got.byte_valid !== want.byte_valid) begin
                report_mismatch($sformatf("byte_valid %b, expected %b",
                                          got.byte_valid, want.byte_valid));
            end
            if (got.found !== want.found) begin
                report_mismatch($sformatf("found %b, expected %b", got.found, want.found));
            end
            if (got.last !== want.last) begin
                report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
            end
            if (want.last && want.found) begin
                hits++;
            end else if (want.last) begin
                misses++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lookup_answers.delete();
            key_len   = 0;
            key_ovf   = 1'b0;
            phase     = PH_START;
            pair_pos  = 0;
            pair_miss = 1'b0;
        end else begin
            if (i_pop && !i_empty) begin
                check_result(i_result);
            end
            if (i_push && !i_full) begin
                step_lookup(i_item);
            end
        end
        o_pending <= lookup_answers.size();
        o_errors  <= errors;
        o_hits    <= hits;
        o_misses  <= misses;
    end

endmodule

// ----- bench/info_string_key_lookup_tb.sv -----
`timescale 1ns / 100ps
// Top of the info string key lookup bench: clock, reset, stimulus and verdict.
// Depends on isk_pkg, the block itself and isk_lookup_checker.

module info_string_key_lookup_tb;
    import isk_pkg::*;

    localparam int         CLK_HALF     = 4;
    localparam int         ITEM_TARGET  = 1700;
    localparam int         IDLE_LIMIT   = 400;
    localparam int         TAIL_CYCLES  = 20;
    localparam logic [1:0] OP_IGNORED   = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic push  = 1'b0;
    logic pop   = 1'b0;
    t_in  item  = '0;
    logic full;
    logic empty;
    t_out result;

    int err_count;
    int pending;
    int hit_count;
    int miss_count;

    int         n_items = 0;
    int         n_keys = 0;
    int         n_long_keys = 0;
    int         n_strings = 0;
    int         send_calm = 0;
    int         recv_calm = 0;
    int         idle_cycles = 0;
    logic [7:0] query[$];

    info_string_key_lookup dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .push     (push),
        .full     (full),
        .i_item   (item),
        .empty    (empty),
        .pop      (pop),
        .o_result (result)
    );

    isk_lookup_checker u_check (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_push   (push),
        .i_full   (full),
        .i_item   (item),
        .i_empty  (empty),
        .i_pop    (pop),
        .i_result (result),
        .o_errors (err_count),
        .o_pending(pending),
        .o_hits   (hit_count),
        .o_misses (miss_count)
    );

    always #CLK_HALF clk = ~clk;

    // Each side mostly waits briefly, sometimes long, and now and then runs flat out.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        case ($urandom_range(0, 3))
            0, 1: return 0;
            2: return $urandom_range(1, 3);
            default: return $urandom_range(0, 17);
        endcase
    endfunction

    function automatic logic [7:0] pick_value_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == SEP_CHAR);
        return c;
    endfunction

    function automatic logic [7:0] pick_key_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'h61 + 8'($urandom_range(0, 2));
            4, 5, 6: return 8'h41 + 8'($urandom_range(0, 2));
            7: return $urandom_range(0, 1) ? UPPER_HI : UPPER_HI + CASE_STEP;
            8: return pick_value_char();
            default: begin
                case ($urandom_range(0, 3))
                    0: return UPPER_LO - 8'h01;
                    1: return UPPER_HI + 8'h01;
                    2: return UPPER_LO + CASE_STEP - 8'h01;
                    default: return UPPER_HI + CASE_STEP + 8'h01;
                endcase
            end
        endcase
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        logic is_alpha;
        is_alpha = (c >= UPPER_LO && c <= UPPER_HI) ||
                   (c >= UPPER_LO + CASE_STEP && c <= UPPER_HI + CASE_STEP);
        return (is_alpha && $urandom_range(0, 1)) ? c ^ CASE_STEP : c;
    endfunction

    task automatic send(input logic [1:0] op, input logic [7:0] b);
        int  gap;
        t_in it;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.operation = op;
        it.data_byte = b;
        push <= 1'b1;
        item <= it;
        do @(posedge clk); while (full);
        if (op != OP_IGNORED) begin
            n_items++;
        end
    endtask

    task automatic wait_drain();
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic append_key(input logic [7:0] c);
        send(OP_APPEND, c);
        query.push_back(c);
    endtask

    task automatic load_key(input int len);
        int i;
        send(OP_CLEAR, 8'($urandom_range(0, 255)));
        query.delete();
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 29) == 0) begin
                append_key(8'($urandom_range(0, 255)));
            end else begin
                append_key(pick_key_char());
            end
        end
        n_keys++;
        if (len > KEY_MAX) begin
            n_long_keys++;
        end
    endtask

    // String bytes occasionally carry noise: an ignored item or a key change mid-scan.
    task automatic string_byte(input logic [7:0] c);
        case ($urandom_range(0, 199))
            0: send(OP_IGNORED, 8'($urandom_range(0, 255)));
            1: append_key(pick_key_char());
            2: begin
                if ($urandom_range(0, 1)) begin
                    send(OP_CLEAR, 8'($urandom_range(0, 255)));
                    query.delete();
                end
            end
            default: ;
        endcase
        send(OP_STRING, c);
    endtask

    task automatic send_string();
        int         pairs;
        int         hit;
        int         p;
        int         i;
        int         kl;
        int         variant;
        logic       cut;
        logic [7:0] pair_key[$];
        pairs = $urandom_range(1, 4);
        hit   = $urandom_range(0, pairs);
        cut   = 1'b0;
        if ($urandom_range(0, 1)) begin
            string_byte(SEP_CHAR);
        end
        for (p = 0; p < pairs && !cut; p++) begin
            if (p == hit) begin
                pair_key = query;
                variant  = $urandom_range(0, 5);
                kl       = pair_key.size();
                if (variant == 4 && kl > 0) begin
                    kl--;
                end
                for (i = 0; i < kl; i++) begin
                    string_byte(flip_case(pair_key[i]));
                end
                if (variant == 5) begin
                    string_byte(pick_key_char());
                end
            end else begin
                kl = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 70)
                                                  : $urandom_range(0, 4);
                for (i = 0; i < kl; i++) begin
                    string_byte(pick_key_char());
                end
            end
            if (p == pairs - 1 && $urandom_range(0, 9) == 0) begin
                cut = 1'b1;
            end else begin
                string_byte(SEP_CHAR);
                kl = $urandom_range(0, 5);
                for (i = 0; i < kl; i++) begin
                    string_byte(pick_value_char());
                end
                if (p < pairs - 1 || $urandom_range(0, 4) == 0) begin
                    string_byte(SEP_CHAR);
                end
            end
        end
        string_byte(END_CHAR);
        n_strings++;
    endtask

    task automatic take_results();
        int stall;
        forever begin
            stall = draw_wait(recv_calm);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    endtask

    initial begin
        while (!rst_n) @(posedge clk);
        take_results();
    end

    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: nothing moved for %0d cycles.", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int r;
        int len;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Match of pair key a to query key A; the value holds Z and FF and ends at a separator.
        send(OP_CLEAR, 8'hFF);
        send(OP_APPEND, "A");
        send(OP_STRING, SEP_CHAR);
        send(OP_STRING, "a");
        send(OP_STRING, SEP_CHAR);
        send(OP_STRING, "Z");
        send(OP_STRING, 8'hFF);
        send(OP_STRING, SEP_CHAR);
        send(OP_STRING, "x");
        send(OP_STRING, END_CHAR);
        // An empty string, an ignored operation, then an empty key against an empty pair key.
        send(OP_STRING, END_CHAR);
        send(OP_IGNORED, 8'hFF);
        send(OP_CLEAR, 8'h00);
        send(OP_STRING, SEP_CHAR);
        send(OP_STRING, SEP_CHAR);
        send(OP_STRING, END_CHAR);
        // The key grows in the middle of a scan, which restarts it.
        send(OP_APPEND, "b");
        send(OP_STRING, "b");
        send(OP_APPEND, "C");
        send(OP_STRING, "B");
        send(OP_STRING, "c");
        send(OP_STRING, SEP_CHAR);
        send(OP_STRING, END_CHAR);
        send(OP_STRING, "q");
        send(OP_STRING, SEP_CHAR);
        send(OP_STRING, "v");
        send(OP_STRING, END_CHAR);
        wait_drain();

        load_key(KEY_MAX + 2);
        send_string();
        while (n_items < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                case ($urandom_range(0, 19))
                    0: len = 0;
                    1: len = KEY_MAX;
                    2: len = KEY_MAX + $urandom_range(1, 4);
                    3: len = $urandom_range(7, KEY_MAX - 1);
                    default: len = $urandom_range(1, 6);
                endcase
                load_key(len);
            end else if (r < 10) begin
                wait_drain();
            end else if (r < 12) begin
                send(OP_IGNORED, 8'($urandom_range(0, 255)));
            end else begin
                send_string();
            end
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d items: %0d query keys (%0d longer than %0d bytes), %0d strings.",
                 n_items, n_keys, n_long_keys, KEY_MAX, n_strings);
        $display("Lookups checked: %0d found, %0d not found.", hit_count, miss_count);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
